[hw/rtl/stc_pkg.sv]
package stc_pkg;

  // Number formats
  localparam int FRAC_BITS       = 24;
  localparam int MAX_FRAC_DIGITS = 7;
  localparam int INT_BITS        = 32;
  localparam int FIX_W           = 56;

  // Derived widths
  localparam int WHOLE_W    = INT_BITS + 1;
  localparam int FRAC_ACC_W = FRAC_BITS + 1;
  localparam int WEIGHT_W   = FRAC_BITS - 3;
  localparam int FDIG_W     = $clog2(MAX_FRAC_DIGITS + 1);
  localparam int MAG_W      = WHOLE_W + FRAC_BITS;

  // Character codes
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CASE_BIT = 8'h20;

  typedef enum logic [1:0] {
    KIND_BOOL = 2'd0,
    KIND_INT  = 2'd1,
    KIND_DEC  = 2'd2,
    KIND_STR  = 2'd3
  } kind_e;

  // Lower-case letters of "true" by position
  function automatic logic [7:0] true_char(input logic [1:0] pos);
    logic [7:0] c;
    unique case (pos)
      2'd0:    c = 8'h74;
      2'd1:    c = 8'h72;
      2'd2:    c = 8'h75;
      default: c = 8'h65;
    endcase
    return c;
  endfunction

  // Lower-case letters of "false" by position
  function automatic logic [7:0] false_char(input logic [2:0] pos);
    logic [7:0] c;
    unique case (pos)
      3'd0:    c = 8'h66;
      3'd1:    c = 8'h61;
      3'd2:    c = 8'h6c;
      3'd3:    c = 8'h73;
      3'd4:    c = 8'h65;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // Weight of fraction digit k: round(2^24 / 10^k)
  function automatic logic [WEIGHT_W-1:0] frac_weight(input logic [FDIG_W-1:0] k);
    logic [WEIGHT_W-1:0] w;
    unique case (k)
      FDIG_W'(1): w = WEIGHT_W'(1677722);
      FDIG_W'(2): w = WEIGHT_W'(167772);
      FDIG_W'(3): w = WEIGHT_W'(16777);
      FDIG_W'(4): w = WEIGHT_W'(1678);
      FDIG_W'(5): w = WEIGHT_W'(168);
      FDIG_W'(6): w = WEIGHT_W'(17);
      FDIG_W'(7): w = WEIGHT_W'(2);
      default:    w = '0;
    endcase
    return w;
  endfunction

endpackage

[hw/rtl/scalar_token_classifier.sv]
// Scalar token classifier.
// Input channel: one token character per transfer (ch_i with has_char_i),
// last_i marks the final transfer of a token. A transfer with has_char_i low
// carries no character; with last_i high it closes the token as it stands.
// Output channel: one result per token, sent after the last input transfer:
// kind_o (boolean, integer, decimal, string) with bool_value_o, int_value_o
// (saturated 32-bit signed), fixed_value_o (56-bit signed, 24 fraction bits)
// and overflow_o. Unused value fields read zero.
// Path: a result passes the input register and then the result register on
// its way to the output.
// Throughput: one character per cycle unless a last transfer waits on the
// stalled result register; set by the digit accumulator (times ten plus
// digit, saturating) and end of token classify/saturate logic ahead of it.
// Reset clears both valid flags and the token state; no result is pending.
// While the receiver stalls, the result holds; characters keep flowing into
// the token state, and only a last transfer waits for the result register,
// which in turn raises in_stall_o.
module scalar_token_classifier (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  ch_i,
  input  logic        has_char_i,
  input  logic        last_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  kind_o,
  output logic        bool_value_o,
  output logic signed [stc_pkg::INT_BITS-1:0] int_value_o,
  output logic signed [stc_pkg::FIX_W-1:0]    fixed_value_o,
  output logic        overflow_o
);

  localparam int WW = stc_pkg::WHOLE_W;
  localparam int FW = stc_pkg::FRAC_ACC_W;
  localparam int DW = stc_pkg::FDIG_W;
  localparam int MW = stc_pkg::MAG_W;
  localparam int IW = stc_pkg::INT_BITS;
  localparam int XW = stc_pkg::FIX_W;

  // Input register
  logic       s1_valid_q;
  logic [7:0] ch_q;
  logic       has_q, last_q;
  logic       out_free, s1_fire, s1_load;

  // Token state
  logic [2:0]    cnt_q, cnt_d;
  logic          neg_q, neg_d, dot_q, dot_d, nn_q, nn_d;
  logic          tm_q, tm_d, fm_q, fm_d, sat_q, sat_d;
  logic [WW-1:0] whole_q, whole_d;
  logic [FW-1:0] frac_q, frac_d;
  logic [DW-1:0] fdig_q, fdig_d;

  // Result register
  logic               out_valid_q;
  stc_pkg::kind_e     kind_q, kind_d;
  logic               bval_q, bval_d, ovf_q, ovf_d;
  logic [IW-1:0]      ival_q, ival_d;
  logic [XW-1:0]      fval_q, fval_d;

  // Per-character decode
  logic [7:0]    low;
  logic [3:0]    digit;
  logic          is_digit;
  logic [WW+3:0] whole_next;
  logic [DW-1:0] fdig_inc;

  // Result arithmetic
  logic [WW-1:0] int_lim;
  logic [IW-1:0] int_mag;
  logic          int_ovf;
  logic [MW-1:0] fix_mag, fix_lim;
  logic [XW-1:0] fix_sat;
  logic          fix_ovf;

  // Handshake: non-last items never wait for the result register
  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_fire    = s1_valid_q && (!last_q || out_free);
  assign s1_load    = !s1_valid_q || s1_fire;
  assign in_stall_o = !s1_load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_load) begin
      s1_valid_q <= in_valid_i;
    end
  end

  // Capture the input payload
  always_ff @(posedge clk_i) begin
    if (s1_load && in_valid_i) begin
      ch_q   <= ch_i;
      has_q  <= has_char_i;
      last_q <= last_i;
    end
  end

  assign low        = ch_q | stc_pkg::CASE_BIT;
  assign digit      = ch_q[3:0];
  assign is_digit   = (ch_q >= stc_pkg::CH_ZERO) && (ch_q <= stc_pkg::CH_NINE);
  assign whole_next = {1'b0, whole_q, 3'b000} + {3'b000, whole_q, 1'b0} + (WW+4)'(digit);
  assign fdig_inc   = fdig_q + DW'(1);

  // Advance the token state by one character
  always_comb begin
    cnt_d   = cnt_q;
    neg_d   = neg_q;
    dot_d   = dot_q;
    nn_d    = nn_q;
    tm_d    = tm_q;
    fm_d    = fm_q;
    sat_d   = sat_q;
    whole_d = whole_q;
    frac_d  = frac_q;
    fdig_d  = fdig_q;
    if (has_q) begin
      if (cnt_q[2] || (low != stc_pkg::true_char(cnt_q[1:0]))) begin
        tm_d = 1'b0;
      end
      if ((cnt_q > 3'd4) || (low != stc_pkg::false_char(cnt_q))) begin
        fm_d = 1'b0;
      end
      priority if ((cnt_q == 3'd0) && (ch_q == stc_pkg::CH_MINUS)) begin
        neg_d = 1'b1;
      end else if (ch_q == stc_pkg::CH_DOT) begin
        if (dot_q) begin
          nn_d = 1'b1;
        end
        dot_d = 1'b1;
      end else if (is_digit) begin
        if (dot_q) begin
          if (fdig_q < DW'(stc_pkg::MAX_FRAC_DIGITS)) begin
            fdig_d = fdig_inc;
            frac_d = frac_q + FW'(digit) * FW'(stc_pkg::frac_weight(fdig_inc));
          end
        end else if (whole_next > (WW+4)'({1'b1, {(WW-1){1'b0}}})) begin
          whole_d = {1'b1, {(WW-1){1'b0}}};
          sat_d   = 1'b1;
        end else begin
          whole_d = whole_next[WW-1:0];
        end
      end else begin
        nn_d = 1'b1;
      end
      if (cnt_q != 3'd7) begin
        cnt_d = cnt_q + 3'd1;
      end
    end
  end

  // Saturate the integer and decimal magnitudes
  assign int_lim = neg_d ? WW'({1'b1, {(IW-1){1'b0}}}) : WW'({1'b0, {(IW-1){1'b1}}});
  assign int_ovf = sat_d || (whole_d > int_lim);
  assign int_mag = int_ovf ? int_lim[IW-1:0] : whole_d[IW-1:0];

  assign fix_mag = {whole_d, {stc_pkg::FRAC_BITS{1'b0}}} + MW'(frac_d);
  assign fix_lim = neg_d ? MW'({1'b1, {(XW-1){1'b0}}}) : MW'({1'b0, {(XW-1){1'b1}}});
  assign fix_ovf = sat_d || (fix_mag > fix_lim);
  assign fix_sat = fix_ovf ? fix_lim[XW-1:0] : fix_mag[XW-1:0];

  // Classify the finished token
  always_comb begin
    kind_d = stc_pkg::KIND_STR;
    bval_d = 1'b0;
    ovf_d  = 1'b0;
    ival_d = '0;
    fval_d = '0;
    priority if (tm_d && (cnt_d == 3'd4)) begin
      kind_d = stc_pkg::KIND_BOOL;
      bval_d = 1'b1;
    end else if (fm_d && (cnt_d == 3'd5)) begin
      kind_d = stc_pkg::KIND_BOOL;
    end else if (!nn_d && !dot_d) begin
      kind_d = stc_pkg::KIND_INT;
      ovf_d  = int_ovf;
      ival_d = neg_d ? (IW'(0) - int_mag) : int_mag;
    end else if (!nn_d) begin
      kind_d = stc_pkg::KIND_DEC;
      ovf_d  = fix_ovf;
      fval_d = neg_d ? (XW'(0) - fix_sat) : fix_sat;
    end else begin
      kind_d = stc_pkg::KIND_STR;
    end
  end

  // Token state register: clear after the last character
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      neg_q   <= 1'b0;
      dot_q   <= 1'b0;
      nn_q    <= 1'b0;
      tm_q    <= 1'b1;
      fm_q    <= 1'b1;
      sat_q   <= 1'b0;
      whole_q <= '0;
      frac_q  <= '0;
      fdig_q  <= '0;
    end else if (s1_fire) begin
      if (last_q) begin
        cnt_q   <= '0;
        neg_q   <= 1'b0;
        dot_q   <= 1'b0;
        nn_q    <= 1'b0;
        tm_q    <= 1'b1;
        fm_q    <= 1'b1;
        sat_q   <= 1'b0;
        whole_q <= '0;
        frac_q  <= '0;
        fdig_q  <= '0;
      end else begin
        cnt_q   <= cnt_d;
        neg_q   <= neg_d;
        dot_q   <= dot_d;
        nn_q    <= nn_d;
        tm_q    <= tm_d;
        fm_q    <= fm_d;
        sat_q   <= sat_d;
        whole_q <= whole_d;
        frac_q  <= frac_d;
        fdig_q  <= fdig_d;
      end
    end
  end

  // Result valid: set on a last transfer, drop once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_fire && last_q) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result payload: load on a last transfer, hold otherwise
  always_ff @(posedge clk_i) begin
    if (s1_fire && last_q) begin
      kind_q <= kind_d;
      bval_q <= bval_d;
      ovf_q  <= ovf_d;
      ival_q <= ival_d;
      fval_q <= fval_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign kind_o        = kind_q;
  assign bool_value_o  = bval_q;
  assign int_value_o   = ival_q;
  assign fixed_value_o = fval_q;
  assign overflow_o    = ovf_q;

endmodule
